// File: sv/prim_minimum_spanning_tree_top_assert.svh
// ----------------------------------------------------------------------------
// prim minimum spanning tree assertion macros
// shared property shapes for the tree engine checks
// ----------------------------------------------------------------------------
`ifndef PRIM_MINIMUM_SPANNING_TREE_TOP_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_TOP_ASSERT_SVH

// same-cycle implication
`define MST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/prim_mst_pkg.sv
// ----------------------------------------------------------------------------
// prim mst package
// sizes, codes, result type and helpers shared by the tree engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package prim_mst_pkg;

	localparam int MAX_NODES   = 16;
	localparam int NODE_BITS   = 4;
	localparam int WEIGHT_BITS = 16;
	localparam int ADDR_BITS   = 2 * NODE_BITS;
	localparam int RAM_DEPTH   = MAX_NODES * MAX_NODES;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_RUN   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_PICK,
		ST_RELAX,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic                          last;
		logic signed [WEIGHT_BITS-1:0] tree_weight;
		logic [NODE_BITS-1:0]          child_node;
		logic [NODE_BITS-1:0]          parent_node;
		logic                          is_edge;
	} result_t;

	// one stored entry per unordered pair, lower node in the high bits
	function automatic logic [ADDR_BITS-1:0] pair_addr(
		input logic [NODE_BITS-1:0] a,
		input logic [NODE_BITS-1:0] b
	);
		logic [ADDR_BITS-1:0] r;
		if (a < b) begin
			r = {a, b};
		end else begin
			r = {b, a};
		end
		return r;
	endfunction

endpackage

// File: sv/prim_mst_ram.sv
// ----------------------------------------------------------------------------
// prim mst ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module prim_mst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/prim_minimum_spanning_tree_top.sv
// ----------------------------------------------------------------------------
// prim minimum spanning tree top
// edge loader and iterative prim tree engine over a 16 node graph
// ----------------------------------------------------------------------------
// Each request carries an action in tuser: add edge, run, or clear. An add
// reads the stored weight of the pair, then keeps the lighter one; clear and
// the unused code are handled in idle. A run grows the tree from the
// start_node register with separate scan and relax compares: every fixed node
// takes a scan for the smallest key, a pick and a relax pass through the
// weight memory; the pick waits while the output side stalls. Tree edges
// come out in the order nodes are fixed, the final one with tlast; a run that
// joins no node gives one result with the edge flag low. The block takes no
// request until a run has handed over its last result to the output register.
`timescale 1ns / 1ps
module prim_minimum_spanning_tree_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // node_a, node_b, edge_weight
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // parent_node, child_node, tree_weight
	output logic        m_axis_tuser,  // is_edge
	output logic        m_axis_tlast
);

	import prim_mst_pkg::*;

	localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(MAX_NODES - 1);

	state_t state_q, state_d;

	logic [NODE_BITS-1:0]          start_q;
	logic [NODE_BITS-1:0]          run_start_q;
	logic [RAM_DEPTH-1:0]          present_q;
	logic [MAX_NODES-1:0]          fixed_q;
	logic [MAX_NODES-1:0]          kvalid_q;
	logic signed [WEIGHT_BITS-1:0] key_q [MAX_NODES];
	logic [NODE_BITS-1:0]          par_q [MAX_NODES];

	logic [NODE_BITS-1:0]          add_a_q, add_b_q;
	logic signed [WEIGHT_BITS-1:0] add_w_q;

	logic [NODE_BITS-1:0]          cnt_q;
	logic                          pick_vld_q;
	logic [NODE_BITS-1:0]          pick_q;
	logic signed [WEIGHT_BITS-1:0] pick_key_q;

	logic                          rel_vld_s1;
	logic [NODE_BITS-1:0]          rel_idx_s1;

	result_t pend_q;
	logic    pend_vld_q;
	result_t out_q;
	logic    out_vld_q;

	logic                          in_acc;
	action_t                       in_act;
	logic [NODE_BITS-1:0]          in_a, in_b;
	logic signed [WEIGHT_BITS-1:0] in_w;
	logic                          out_free;
	logic                          out_load;
	result_t                       out_d;
	logic                          scan_take;
	logic [ADDR_BITS-1:0]          ram_raddr;
	logic [ADDR_BITS-1:0]          add_addr;
	logic signed [WEIGHT_BITS-1:0] ram_rdata;
	logic                          add_wr;
	logic [ADDR_BITS-1:0]          rel_addr;
	logic                          rel_upd;
	result_t                       new_res;

	assign in_act = action_t'(s_axis_tuser);
	assign in_a   = s_axis_tdata[3:0];
	assign in_b   = s_axis_tdata[7:4];
	assign in_w   = s_axis_tdata[23:8];
	assign in_acc = s_axis_tvalid && s_axis_tready;

	assign out_free = !out_vld_q || m_axis_tready;

	assign add_addr = pair_addr(add_a_q, add_b_q);
	assign add_wr   = (state_q == ST_ADD) && (!present_q[add_addr] || (add_w_q < ram_rdata));

	assign ram_raddr = (state_q == ST_IDLE) ? pair_addr(in_a, in_b) : pair_addr(pick_q, cnt_q);

	prim_mst_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (RAM_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (add_wr),
		.waddr (add_addr),
		.wdata (add_w_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// compare logic: scan candidate and relax update
	assign scan_take = !fixed_q[cnt_q] && kvalid_q[cnt_q] &&
		(!pick_vld_q || (key_q[cnt_q] < pick_key_q));

	assign rel_addr = pair_addr(pick_q, rel_idx_s1);
	assign rel_upd  = rel_vld_s1 && present_q[rel_addr] && !fixed_q[rel_idx_s1] &&
		(!kvalid_q[rel_idx_s1] || (ram_rdata < key_q[rel_idx_s1]));

	always_comb begin
		new_res.is_edge     = 1'b1;
		new_res.parent_node = par_q[pick_q];
		new_res.child_node  = pick_q;
		new_res.tree_weight = pick_key_q;
		new_res.last        = 1'b0;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		out_d         = pend_q;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (in_act)
						ACT_ADD: state_d = ST_ADD;
						ACT_RUN: state_d = ST_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (cnt_q == LAST_NODE) begin
					state_d = (pick_vld_q || scan_take) ? ST_PICK : ST_FLUSH;
				end
			end
			ST_PICK: begin
				if (pick_q == run_start_q || !pend_vld_q) begin
					state_d = ST_RELAX;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_RELAX;
				end
			end
			ST_RELAX: begin
				if (cnt_q == LAST_NODE) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_SCAN;
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (pend_vld_q) begin
						out_d.last = 1'b1;
					end else begin
						out_d = '{is_edge: 1'b0, parent_node: '0, child_node: '0,
							tree_weight: '0, last: 1'b1};
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= NODE_BITS'(1);
			present_q  <= '0;
			fixed_q    <= '0;
			kvalid_q   <= '0;
			cnt_q      <= '0;
			pick_vld_q <= 1'b0;
			rel_vld_s1 <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				start_q <= cfg_wdata;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			rel_vld_s1 <= (state_q == ST_RELAX);
			if (rel_upd) begin
				kvalid_q[rel_idx_s1] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_act == ACT_CLEAR) begin
						present_q <= '0;
					end
					if (in_acc && in_act == ACT_RUN) begin
						fixed_q    <= '0;
						kvalid_q   <= MAX_NODES'(1) << start_q;
						cnt_q      <= '0;
						pick_vld_q <= 1'b0;
						pend_vld_q <= 1'b0;
					end
				end
				ST_ADD: begin
					if (add_wr) begin
						present_q[add_addr] <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_take) begin
						pick_vld_q <= 1'b1;
					end
					cnt_q <= cnt_q + NODE_BITS'(1);
				end
				ST_PICK: begin
					if (state_d == ST_RELAX) begin
						fixed_q[pick_q] <= 1'b1;
						cnt_q           <= '0;
						if (pick_q != run_start_q) begin
							pend_vld_q <= 1'b1;
						end
					end
				end
				ST_RELAX: begin
					cnt_q <= cnt_q + NODE_BITS'(1);
				end
				ST_DRAIN: begin
					pick_vld_q <= 1'b0;
					cnt_q      <= '0;
				end
				ST_FLUSH: begin
					if (out_load) begin
						pend_vld_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			add_a_q <= in_a;
			add_b_q <= in_b;
			add_w_q <= in_w;
		end
		if (in_acc && in_act == ACT_RUN) begin
			run_start_q    <= start_q;
			key_q[start_q] <= '0;
			for (int n = 0; n < MAX_NODES; n++) begin
				par_q[n] <= '0;
			end
		end
		if (state_q == ST_SCAN && scan_take) begin
			pick_q     <= cnt_q;
			pick_key_q <= key_q[cnt_q];
		end
		if (state_q == ST_RELAX) begin
			rel_idx_s1 <= cnt_q;
		end
		if (rel_upd) begin
			key_q[rel_idx_s1] <= ram_rdata;
			par_q[rel_idx_s1] <= pick_q;
		end
		if (state_q == ST_PICK && state_d == ST_RELAX && pick_q != run_start_q) begin
			pend_q <= new_res;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q.tree_weight, out_q.child_node, out_q.parent_node};
	assign m_axis_tuser  = out_q.is_edge;
	assign m_axis_tlast  = out_q.last;

	`include "prim_minimum_spanning_tree_top_assert.svh"

	`MST_ASSERT_NOW(a_relax_from_fixed, rel_vld_s1, fixed_q[pick_q], "relax source not fixed")
	`MST_ASSERT_NOW(a_empty_is_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast,
		"empty tree result without last")
	`MST_ASSERT_NOW(a_pending_fixed, pend_vld_q && state_q != ST_IDLE,
		fixed_q[pend_q.child_node], "pending child not fixed")
	`MST_ASSERT_NEXT(a_pick_then_relax, state_q == ST_PICK && state_d == ST_RELAX,
		fixed_q[pick_q] && cnt_q == '0, "pick did not fix node")

endmodule
